// ===== hw/rtl/ocb_pkg.sv =====
package ocb_pkg;

   localparam int MAX_CANDIDATES = 64;
   localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int K_W            = $clog2(MAX_CANDIDATES + 2);
   localparam int KEY_W          = 20;
   localparam int DIV_W          = 19;
   localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
   localparam int REGPROD_W      = 10;
   localparam int PROD_W         = REGPROD_W + K_W;
   localparam int BLOCK_W        = 12;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 19;

   localparam logic [CSR_ADDR_W-1:0] CSR_WAVE_SIZE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_THREADS    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_WAVES_SIMD = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_VGPR_FILE      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIMDS_PER_CU   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LDS_BYTES      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_WAVES_CU   = 3'd6;

   typedef struct packed {
      logic [12:0] regs_per_thread;
      logic [18:0] lds_per_group;
      logic [10:0] size_clamp;
   } req_type;

   typedef struct packed {
      logic [10:0] block_size;
      logic [8:0]  waves_resident;
      logic        found;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hw/rtl/occupancy_block_ranker.sv =====
// Occupancy block ranker.
// Configuration: csr_we/csr_addr/csr_wdata write one register per beat,
// immediately; write only while busy is low.
// Request: a beat is taken when start is high and busy is low; busy then
// stays high until the cycle that carries the final result beat.
// Results: rsp_valid is high for one cycle per result beat on rsp_data,
// best occupancy first, larger block first on ties, last flagged. When no
// size fits, a single beat with found low and last high is sent.
// Sequence: a VGPR setup division, plus an LDS setup division when
// lds_per_group is nonzero, then per tried size an issue state and one
// division, then per reported result one scan of the candidate RAM over
// the tried sizes. All divisions share one serial radix-2 divider; the
// scans are bounded by the single RAM read port.
// The receiver cannot stall results. Reset restores register defaults and
// returns the sequencer to idle; the candidate RAM is not cleared.
module occupancy_block_ranker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ocb_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output ocb_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [ocb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ocb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ocb_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_VG   = 4'd1;
   localparam logic [3:0] ST_LDS  = 4'd2;
   localparam logic [3:0] ST_CAND = 4'd3;
   localparam logic [3:0] ST_DIVK = 4'd4;
   localparam logic [3:0] ST_SCAN = 4'd5;
   localparam logic [3:0] ST_EMIT = 4'd6;
   localparam logic [3:0] ST_NONE = 4'd7;

   logic [6:0]  wave_size_ff;
   logic [10:0] max_threads_ff;
   logic [5:0]  max_waves_simd_ff;
   logic [12:0] vgpr_file_ff;
   logic [3:0]  simds_ff;
   logic [18:0] lds_bytes_ff;
   logic [8:0]  max_waves_cu_ff;

   logic [3:0]           state_ff;
   req_type              req_ff;
   logic [REGPROD_W-1:0] regprod_ff;
   logic [DIV_W-1:0]     by_lds_ff;
   logic [K_W-1:0]       k_ff;
   logic [BLOCK_W-1:0]   block_ff;
   logic [K_W-1:0]       surv_ff;
   logic [K_W-1:0]       tried_ff;
   logic [K_W-1:0]       addr_ff;
   logic                 rd_ok_ff;
   logic [KEY_W:0]       thresh_ff;
   logic [KEY_W-1:0]     best_ff;
   logic [K_W-1:0]       emit_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic [5:0]       per_simd;
   logic [9:0]       by_regs;
   logic [DIV_W-1:0] groups;
   logic [PROD_W-1:0] prod;
   logic [8:0]       occ;
   logic [KEY_W-1:0] key;
   logic             stop;
   logic             ram_we;
   logic [KEY_W-1:0] ram_rdata;

   assign per_simd = (div_rsp.quotient < DIV_W'(max_waves_simd_ff)) ?
                     div_rsp.quotient[5:0] : max_waves_simd_ff;
   assign by_regs = div_rsp.quotient[9:0];
   assign groups  = (req_ff.lds_per_group != '0 && by_lds_ff < DIV_W'(by_regs)) ?
                    by_lds_ff : DIV_W'(by_regs);
   assign prod    = PROD_W'(groups[REGPROD_W-1:0]) * PROD_W'(k_ff);
   assign occ     = (prod < PROD_W'(max_waves_cu_ff)) ? prod[8:0] : max_waves_cu_ff;
   assign key     = (occ != '0) ? {occ, block_ff[10:0]} : '0;
   assign stop    = (k_ff > K_W'(MAX_CANDIDATES)) ||
                    (block_ff > BLOCK_W'(max_threads_ff)) ||
                    (req_ff.size_clamp != '0 && block_ff > BLOCK_W'(req_ff.size_clamp));
   assign ram_we  = (state_ff == ST_DIVK) && div_rsp.done;

   always_comb begin
      div_req = '0;
      unique case (state_ff)
         ST_IDLE: begin
            div_req.start    = start && wave_size_ff != '0;
            div_req.dividend = DIV_W'(vgpr_file_ff);
            div_req.divisor  = DIV_W'((req_data.regs_per_thread == '0) ?
                                      13'd1 : req_data.regs_per_thread);
         end
         ST_VG: begin
            div_req.start    = div_rsp.done && req_ff.lds_per_group != '0;
            div_req.dividend = lds_bytes_ff;
            div_req.divisor  = req_ff.lds_per_group;
         end
         ST_CAND: begin
            div_req.start    = !stop;
            div_req.dividend = DIV_W'(regprod_ff);
            div_req.divisor  = DIV_W'(k_ff);
         end
         default: div_req = '0;
      endcase
   end

   ocb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ocb_ram #(.WIDTH(KEY_W), .DEPTH(MAX_CANDIDATES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IDX_W'(k_ff - 1'b1)),
      .wdata (key),
      .raddr (addr_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_size_ff      <= 7'd64;
         max_threads_ff    <= 11'd1024;
         max_waves_simd_ff <= 6'd16;
         vgpr_file_ff      <= 13'd512;
         simds_ff          <= 4'd4;
         lds_bytes_ff      <= 19'd65536;
         max_waves_cu_ff   <= 9'd40;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WAVE_SIZE:      wave_size_ff      <= csr_wdata[6:0];
            CSR_MAX_THREADS:    max_threads_ff    <= csr_wdata[10:0];
            CSR_MAX_WAVES_SIMD: max_waves_simd_ff <= csr_wdata[5:0];
            CSR_VGPR_FILE:      vgpr_file_ff      <= csr_wdata[12:0];
            CSR_SIMDS_PER_CU:   simds_ff          <= csr_wdata[3:0];
            CSR_LDS_BYTES:      lds_bytes_ff      <= csr_wdata;
            CSR_MAX_WAVES_CU:   max_waves_cu_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  k_ff     <= K_W'(1);
                  block_ff <= BLOCK_W'(wave_size_ff);
                  surv_ff  <= '0;
                  state_ff <= (wave_size_ff == '0) ? ST_NONE : ST_VG;
               end
            end
            ST_VG: begin
               if (div_rsp.done) begin
                  regprod_ff <= REGPROD_W'(per_simd) * REGPROD_W'(simds_ff);
                  state_ff   <= (req_ff.lds_per_group != '0) ? ST_LDS : ST_CAND;
               end
            end
            ST_LDS: begin
               if (div_rsp.done) begin
                  by_lds_ff <= div_rsp.quotient;
                  state_ff  <= ST_CAND;
               end
            end
            ST_CAND: begin
               if (stop) begin
                  tried_ff  <= k_ff - 1'b1;
                  addr_ff   <= '0;
                  rd_ok_ff  <= 1'b0;
                  thresh_ff <= '1;
                  best_ff   <= '0;
                  emit_ff   <= '0;
                  state_ff  <= (surv_ff == '0) ? ST_NONE : ST_SCAN;
               end else begin
                  state_ff <= ST_DIVK;
               end
            end
            ST_DIVK: begin
               if (div_rsp.done) begin
                  if (occ != '0) begin
                     surv_ff <= surv_ff + 1'b1;
                  end
                  k_ff     <= k_ff + 1'b1;
                  block_ff <= block_ff + BLOCK_W'(wave_size_ff);
                  state_ff <= ST_CAND;
               end
            end
            ST_SCAN: begin
               rd_ok_ff <= addr_ff < tried_ff;
               if (addr_ff < tried_ff) begin
                  addr_ff <= addr_ff + 1'b1;
               end
               if (rd_ok_ff && {1'b0, ram_rdata} < thresh_ff && ram_rdata > best_ff) begin
                  best_ff <= ram_rdata;
               end
               if (addr_ff == tried_ff && !rd_ok_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff           <= 1'b1;
               rsp_ff.block_size      <= best_ff[10:0];
               rsp_ff.waves_resident  <= best_ff[19:11];
               rsp_ff.found           <= 1'b1;
               rsp_ff.last            <= (emit_ff + 1'b1) == surv_ff;
               emit_ff                <= emit_ff + 1'b1;
               thresh_ff              <= {1'b0, best_ff};
               best_ff                <= '0;
               addr_ff                <= '0;
               rd_ok_ff               <= 1'b0;
               state_ff <= ((emit_ff + 1'b1) == surv_ff) ? ST_IDLE : ST_SCAN;
            end
            ST_NONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= '{block_size: '0, waves_resident: '0, found: 1'b0,
                                 last: 1'b1};
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/ocb_ram.sv =====
module ocb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ocb_div.sv =====
module ocb_div (
   input  logic                clock,
   input  logic                reset,
   input  ocb_pkg::div_req_type div_req,
   output ocb_pkg::div_rsp_type div_rsp
);
   import ocb_pkg::*;

   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            quo_ff <= div_req.dividend;
            den_ff <= div_req.divisor;
         end else if (run_ff) begin
            rem_ff <= fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== hw/rtl/ocb_checker.sv =====
module ocb_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ocb_pkg::rsp_type rsp_data
);
   import ocb_pkg::*;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken without going busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("idle before final result beat");

   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy |-> rsp_data.last)
      else $error("result beat while idle is not last");

   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.last && rsp_data.block_size == '0 && rsp_data.waves_resident == '0)
      else $error("malformed no-fit beat");

   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> !rsp_valid)
      else $error("result beats back to back");

endmodule

bind occupancy_block_ranker ocb_checker u_ocb_checker (.*);

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ocb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   req_type     pending_reqs[$];
   rsp_type     ranked_sizes[$];
   int unsigned dev_cfg[7];
   int unsigned idle_pct;
   int          fails = 0;

   occupancy_block_ranker u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic int unsigned min_u(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic int unsigned occupancy_of(int unsigned blk, int unsigned regs,
                                                int unsigned lds);
      int unsigned vg, per_wg, per_simd, by_regs, by_lds, groups;
      vg = regs == 0 ? 1 : regs;
      per_wg = blk / dev_cfg[CSR_WAVE_SIZE];
      if (per_wg == 0) return 0;
      per_simd = min_u(dev_cfg[CSR_MAX_WAVES_SIMD], dev_cfg[CSR_VGPR_FILE] / vg);
      by_regs = (per_simd * dev_cfg[CSR_SIMDS_PER_CU]) / per_wg;
      by_lds = lds == 0 ? by_regs : dev_cfg[CSR_LDS_BYTES] / lds;
      groups = min_u(by_regs, by_lds);
      if (groups == 0) return 0;
      return min_u(dev_cfg[CSR_MAX_WAVES_CU], groups * per_wg);
   endfunction

   task automatic rank_sizes(req_type r);
      int unsigned keys[64];
      int unsigned n, blk, occ, key, j;
      rsp_type     e;
      n = 0;
      if (dev_cfg[CSR_WAVE_SIZE] != 0) begin
         blk = dev_cfg[CSR_WAVE_SIZE];
         for (int t = 0; t < MAX_CANDIDATES; t++) begin
            if (blk > dev_cfg[CSR_MAX_THREADS]) break;
            if (r.size_clamp != 0 && blk > r.size_clamp) break;
            occ = occupancy_of(blk, r.regs_per_thread, r.lds_per_group);
            if (occ != 0) begin
               key = ((occ & 'h1FF) << 11) | (blk & 'h7FF);
               j = n;
               while (j > 0 && keys[j-1] < key) begin
                  keys[j] = keys[j-1];
                  j--;
               end
               keys[j] = key;
               n++;
            end
            blk += dev_cfg[CSR_WAVE_SIZE];
         end
      end
      if (n == 0) begin
         e = '0;
         e.last = 1'b1;
         ranked_sizes = {ranked_sizes, e};
      end
      for (int i = 0; i < n; i++) begin
         e.block_size = keys[i][10:0];
         e.waves_resident = keys[i][19:11];
         e.found = 1'b1;
         e.last = (i + 1 == n);
         ranked_sizes = {ranked_sizes, e};
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) rank_sizes(req_data);
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               start <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (ranked_sizes.size() == 0) begin
            $error("unexpected beat %p", rsp_data);
            fails++;
         end else begin
            e = ranked_sizes.pop_front();
            if (rsp_data.block_size !== e.block_size) begin
               $error("block_size exp %0d got %0d", e.block_size, rsp_data.block_size);
               fails++;
            end
            if (rsp_data.waves_resident !== e.waves_resident) begin
               $error("waves_resident exp %0d got %0d", e.waves_resident,
                      rsp_data.waves_resident);
               fails++;
            end
            if (rsp_data.found !== e.found) begin
               $error("found exp %0d got %0d", e.found, rsp_data.found);
               fails++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last);
               fails++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, int unsigned val);
      int unsigned masks[7] = '{'h7F, 'h7FF, 'h3F, 'h1FFF, 'hF, 'h7FFFF, 'h1FF};
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      dev_cfg[idx] = val & masks[idx];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_device(int unsigned w, int unsigned mt, int unsigned mws,
                             int unsigned vg, int unsigned s, int unsigned lds,
                             int unsigned mc);
      write_reg(CSR_WAVE_SIZE, w);
      write_reg(CSR_MAX_THREADS, mt);
      write_reg(CSR_MAX_WAVES_SIMD, mws);
      write_reg(CSR_VGPR_FILE, vg);
      write_reg(CSR_SIMDS_PER_CU, s);
      write_reg(CSR_LDS_BYTES, lds);
      write_reg(CSR_MAX_WAVES_CU, mc);
   endtask

   task automatic add_req(int unsigned regs, int unsigned lds, int unsigned clamp);
      req_type r;
      r.regs_per_thread = 13'(regs);
      r.lds_per_group = 19'(lds);
      r.size_clamp = 11'(clamp);
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_random_reqs(int n);
      int unsigned regs, lds, clamp;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: regs = $urandom_range(0, 8191);
            1: regs = $urandom_range(0, 4096);
            default: regs = $urandom_range(0, 256);
         endcase
         case ($urandom_range(0, 4))
            0: lds = 0;
            1: lds = $urandom_range(0, 524287);
            2: lds = $urandom_range(0, 262144);
            default: lds = $urandom_range(1, 32768);
         endcase
         case ($urandom_range(0, 3))
            0: clamp = 0;
            1: clamp = $urandom_range(0, 2047);
            default: clamp = $urandom_range(0, 1024);
         endcase
         add_req(regs, lds, clamp);
      end
   endtask

   task automatic drain;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (start || busy || ranked_sizes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_idle[4] = '{0, 85, 0, 12};
      idle_pct = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      dev_cfg = '{64, 1024, 16, 512, 4, 65536, 40};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults: field extremes, nothing fits, clamps
      add_req(0, 0, 0);
      add_req(1, 1, 1);
      add_req(4096, 262144, 1024);
      add_req(8191, 524287, 2047);
      add_req(32, 0, 64);
      add_req(513, 0, 0);
      add_req(16, 4096, 0);
      add_req(64, 65537, 0);
      add_req(128, 16384, 512);
      drain();

      // 64 sizes tried, larger ignored
      set_device(16, 2047, 32, 4096, 8, 262144, 256);
      idle_pct = 85;
      add_req(0, 0, 0);
      add_req(1, 1, 2047);
      add_req(200, 8000, 700);
      drain();

      // lower extremes, LDS per CU zero
      set_device(64, 16, 1, 1, 1, 0, 1);
      add_req(0, 0, 0);
      drain();
      set_device(16, 1024, 1, 1, 1, 0, 1);
      idle_pct = 12;
      add_req(0, 0, 0);
      add_req(1, 5, 0);
      drain();

      // wave size zero, zero simds, wave beyond range
      set_device(0, 1024, 16, 512, 4, 65536, 40);
      add_req(1, 0, 0);
      drain();
      set_device(127, 2047, 63, 8191, 0, 524287, 511);
      add_req(1, 0, 0);
      drain();
      set_device(127, 2047, 63, 8191, 15, 524287, 511);
      add_req(1, 0, 0);
      add_req(2, 1000, 0);
      drain();

      for (int p = 0; p < 8; p++) begin
         set_device($urandom_range(16, 64), $urandom_range(16, 1024),
                    $urandom_range(1, 32), $urandom_range(1, 4096),
                    $urandom_range(1, 8), $urandom_range(0, 262144),
                    $urandom_range(1, 256));
         idle_pct = phase_idle[p % 4];
         add_random_reqs(8);
         drain();
         add_random_reqs(8);
         drain();
      end

      if (fails == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
